// ===== hdl/complex_magnitude_peak_assert.svh =====
// assertion macros for the complex magnitude peak detector
// depends on: nothing; included by the modules that check their own logic
`ifndef COMPLEX_MAGNITUDE_PEAK_ASSERT_SVH
`define COMPLEX_MAGNITUDE_PEAK_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define CMP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define CMP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/cmp_pkg.sv =====
// shared types and constants for the complex magnitude peak detector
// depends on: nothing
package cmp_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int MAG_WIDTH            = 16;

   // control that travels alongside each word down the pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

endpackage

// ===== hdl/cmp_sqrt_cell.sv =====
// one cell of the square root chain: settles one root bit per cell
// depends on: cmp_pkg
module cmp_sqrt_cell #(
   parameter int XW  = 32,
   parameter int RW  = 16,
   parameter int BIT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  cmp_pkg::ctl_type ctl_in,
   input  logic [XW-1:0]    rem_in,
   input  logic [RW-1:0]    root_in,
   output cmp_pkg::ctl_type ctl_out,
   output logic [XW-1:0]    rem_out,
   output logic [RW-1:0]    root_out
);
   import cmp_pkg::*;

   ctl_type       ctl_ff;
   logic [XW-1:0] rem_ff, rem_nx_in;
   logic [RW-1:0] root_ff, root_nx_in;
   logic [XW:0]   trial;
   logic          take;

   // (root + 2^bit)^2 - root^2 = root*2^(bit+1) + 2^(2*bit)
   always_comb begin
      trial = ((XW+1)'(root_in) << (BIT + 1)) + ((XW+1)'(1) << (2 * BIT));
      take  = {1'b0, rem_in} >= trial;
      rem_nx_in  = take ? XW'({1'b0, rem_in} - trial) : rem_in;
      root_nx_in = take ? (root_in | (RW'(1) << BIT)) : root_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_nx_in;
         root_ff <= root_nx_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

// ===== hdl/cmp_peak_track.sv =====
// saturates the root, tracks the running peak and holds the output word
// depends on: cmp_pkg, complex_magnitude_peak_assert.svh
module cmp_peak_track #(
   parameter int RW = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  cmp_pkg::ctl_type                ctl_in,
   input  logic [RW-1:0]                   root_in,
   output logic                            out_valid,
   output logic [cmp_pkg::MAG_WIDTH-1:0]   magnitude,
   output logic [cmp_pkg::MAG_WIDTH-1:0]   peak,
   output logic                            last
);
   import cmp_pkg::*;
   `include "complex_magnitude_peak_assert.svh"

   localparam int EXT_W = (RW > MAG_WIDTH) ? RW : MAG_WIDTH;

   logic [EXT_W-1:0]     root_ext;
   logic [MAG_WIDTH-1:0] mag;
   logic [MAG_WIDTH-1:0] peak_sel;
   logic                 load;
   logic [MAG_WIDTH-1:0] running_peak_ff, running_peak_in;
   logic                 valid_ff;
   logic [MAG_WIDTH-1:0] mag_ff, peak_ff;
   logic                 last_ff;

   always_comb begin
      root_ext = EXT_W'(root_in);
      mag      = (root_ext > EXT_W'({MAG_WIDTH{1'b1}})) ? {MAG_WIDTH{1'b1}}
                                                        : root_ext[MAG_WIDTH-1:0];
      peak_sel = (mag > running_peak_ff) ? mag : running_peak_ff;
      load     = advance && ctl_in.valid;
      running_peak_in = running_peak_ff;
      if (load) begin
         running_peak_in = ctl_in.last ? '0 : peak_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_peak_ff <= '0;
         valid_ff        <= 1'b0;
      end else begin
         running_peak_ff <= running_peak_in;
         if (advance) begin
            valid_ff <= ctl_in.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff  <= mag;
         peak_ff <= peak_sel;
         last_ff <= ctl_in.last;
      end
   end

   assign out_valid = valid_ff;
   assign magnitude = mag_ff;
   assign peak      = peak_ff;
   assign last      = last_ff;

   `CMP_ASSERT_NEXT(a_peak_clears_on_last, load && ctl_in.last, running_peak_ff == '0)
   `CMP_ASSERT_NEXT(a_peak_never_drops, load && !ctl_in.last,
                    running_peak_ff >= $past(running_peak_ff))

endmodule

// ===== hdl/complex_magnitude_peak.sv =====
// top level of the complex magnitude peak detector
// depends on: cmp_pkg, cmp_sqrt_cell, cmp_peak_track, complex_magnitude_peak_assert.svh
//
// usage
//   req channel: one complex bin per word (real, imaginary, last flag),
//   valid/ready handshake, taken when req_valid and req_ready are high
//   rsp channel: one word per bin with floor(sqrt(re^2 + im^2)), the running
//   peak of the sequence including this bin, and the copied last flag
//   a word marked last closes the sequence: its peak is the sequence peak and
//   the running peak returns to zero for the next bin
//   pipeline stages: abs, square, sum, one cell per root bit, output register;
//   abs loads at the accept
//   throughput: one word per cycle when not stalled; the whole pipeline moves in
//   lockstep, one root bit settled per cell, so chain length sets latency not rate
//   stall: when the output word is held (rsp_valid high, rsp_ready low) every
//   stage freezes and req_ready drops in the same cycle; nothing is lost
//   reset: synchronous, clears all stage valid bits and the running peak
//   magnitudes above 16 bits (only for SAMPLE_WIDTH > 16) saturate to all ones
module complex_magnitude_peak #(
   parameter int SAMPLE_WIDTH = cmp_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_real_part,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_imag_part,
   input  logic                                 req_last_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [cmp_pkg::MAG_WIDTH-1:0]        rsp_magnitude_out,
   output logic [cmp_pkg::MAG_WIDTH-1:0]        rsp_peak_out,
   output logic                                 rsp_last_out
);
   import cmp_pkg::*;
   `include "complex_magnitude_peak_assert.svh"

   localparam int RW = SAMPLE_WIDTH;       // root width
   localparam int XW = 2 * SAMPLE_WIDTH;   // sum of squares width

   // pipeline moves whenever the output word is free or being taken
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage 1: absolute values
   ctl_type                 ctl_s1_ff, ctl_s2_ff, ctl_s3_ff;
   logic [SAMPLE_WIDTH-1:0] abs_re_ff, abs_im_ff;
   logic [SAMPLE_WIDTH-1:0] abs_re_in, abs_im_in;
   // stage 2: squares
   logic [XW-1:0]           sq_re_ff, sq_im_ff;
   // stage 3: sum of squares, head of the cell chain
   logic [XW-1:0]           sum_ff;
   ctl_type                 ctl_in_word;

   always_comb begin
      abs_re_in = req_real_part[SAMPLE_WIDTH-1] ? (~req_real_part + 1'b1) : req_real_part;
      abs_im_in = req_imag_part[SAMPLE_WIDTH-1] ? (~req_imag_part + 1'b1) : req_imag_part;
      ctl_in_word.valid = req_valid;
      ctl_in_word.last  = req_last_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s1_ff <= '0;
         ctl_s2_ff <= '0;
         ctl_s3_ff <= '0;
      end else if (advance) begin
         ctl_s1_ff <= ctl_in_word;
         ctl_s2_ff <= ctl_s1_ff;
         ctl_s3_ff <= ctl_s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         abs_re_ff <= abs_re_in;
         abs_im_ff <= abs_im_in;
         sq_re_ff  <= XW'(abs_re_ff) * XW'(abs_re_ff);
         sq_im_ff  <= XW'(abs_im_ff) * XW'(abs_im_ff);
         sum_ff    <= sq_re_ff + sq_im_ff;
      end
   end

   // chain of square root cells, most significant root bit first
   ctl_type       ctl_chain  [0:RW];
   logic [XW-1:0] rem_chain  [0:RW];
   logic [RW-1:0] root_chain [0:RW];

   assign ctl_chain[0]  = ctl_s3_ff;
   assign rem_chain[0]  = sum_ff;
   assign root_chain[0] = '0;

   for (genvar i = 0; i < RW; i++) begin : g_cell
      cmp_sqrt_cell #(
         .XW  (XW),
         .RW  (RW),
         .BIT (RW - 1 - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .ctl_in   (ctl_chain[i]),
         .rem_in   (rem_chain[i]),
         .root_in  (root_chain[i]),
         .ctl_out  (ctl_chain[i+1]),
         .rem_out  (rem_chain[i+1]),
         .root_out (root_chain[i+1])
      );
   end

   // saturate, track peak, hold output word
   cmp_peak_track #(
      .RW (RW)
   ) u_peak (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl_in    (ctl_chain[RW]),
      .root_in   (root_chain[RW]),
      .out_valid (rsp_valid),
      .magnitude (rsp_magnitude_out),
      .peak      (rsp_peak_out),
      .last      (rsp_last_out)
   );

   // a finished root leaves a remainder no larger than twice the root
   `CMP_ASSERT_NOW(a_root_is_floor, ctl_chain[RW].valid,
                   {1'b0, rem_chain[RW]} <= ((XW+1)'(root_chain[RW]) << 1))
   `CMP_ASSERT_NOW(a_peak_covers_mag, rsp_valid, rsp_peak_out >= rsp_magnitude_out)

endmodule
